// ===== design/qmsm_pkg.sv =====
// Package for the quadratic map sorted merge block.
// Holds the shared widths, register indexes, queue entry, coefficient and state types.
// No dependencies; every other design file refers to it by scoped names.
package qmsm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int VALUE_W     = 47;
    localparam int POS_W       = 6;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;
    localparam int QUEUE_DEPTH = 2;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_COEF_SQUARE   = 2'd0;
    localparam logic [1:0] REG_COEF_LINEAR   = 2'd1;
    localparam logic [1:0] REG_COEF_CONSTANT = 2'd2;

    // Reset values of the coefficients.
    localparam logic signed [COEF_W-1:0] COEF_SQUARE_RST   = 16'sd1;
    localparam logic signed [COEF_W-1:0] COEF_LINEAR_RST   = 16'sd0;
    localparam logic signed [COEF_W-1:0] COEF_CONSTANT_RST = 16'sd0;

    typedef struct packed {
        logic signed [COEF_W-1:0] square;
        logic signed [COEF_W-1:0] linear;
        logic signed [COEF_W-1:0] constant;
    } coef_t;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } q_entry_t;

    typedef enum logic [1:0] {
        BK_LOAD,
        BK_MAP,
        BK_PRIME,
        BK_MERGE
    } back_state_t;

    // Status of the back end, seen by the top level.
    typedef struct packed {
        logic loading;
        logic merging;
    } back_stat_t;

endpackage

// ===== design/qmsm_in_if.sv =====
// Input channel interface: one sample and its end-of-set flag per transaction.
// Depends on qmsm_pkg for the sample width.
interface qmsm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [qmsm_pkg::SAMPLE_W-1:0] sample;
    logic                                 end_of_set;

    modport source (output valid, output sample, output end_of_set, input ready);
    modport sink (input valid, input sample, input end_of_set, output ready);
endinterface

// ===== design/qmsm_out_if.sv =====
// Output channel interface: one mapped value with its sorted place per transaction.
// Depends on qmsm_pkg for the value and position widths.
interface qmsm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [qmsm_pkg::VALUE_W-1:0] mapped_value;
    logic [qmsm_pkg::POS_W-1:0]          position;
    logic                                end_of_run;

    modport source (output valid, output mapped_value, output position,
                    output end_of_run, input ready);
    modport sink (input valid, input mapped_value, input position,
                  input end_of_run, output ready);
endinterface

// ===== design/qmsm_cfg.sv =====
// APB-style register file for the three mapping coefficients.
// Depends on qmsm_pkg for the register indexes, reset values and coef_t.
module qmsm_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [qmsm_pkg::APB_AW-1:0]   paddr,
    input  logic [qmsm_pkg::APB_DW-1:0]   pwdata,
    output logic [qmsm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output qmsm_pkg::coef_t               coef
);

    logic signed [qmsm_pkg::COEF_W-1:0] square_reg;
    logic signed [qmsm_pkg::COEF_W-1:0] linear_reg;
    logic signed [qmsm_pkg::COEF_W-1:0] constant_reg;
    logic                               wr_en;
    logic [1:0]                         reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg   <= qmsm_pkg::COEF_SQUARE_RST;
            linear_reg   <= qmsm_pkg::COEF_LINEAR_RST;
            constant_reg <= qmsm_pkg::COEF_CONSTANT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                qmsm_pkg::REG_COEF_SQUARE:   square_reg   <= pwdata[qmsm_pkg::COEF_W-1:0];
                qmsm_pkg::REG_COEF_LINEAR:   linear_reg   <= pwdata[qmsm_pkg::COEF_W-1:0];
                qmsm_pkg::REG_COEF_CONSTANT: constant_reg <= pwdata[qmsm_pkg::COEF_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Read data.
    always_comb
    begin
        unique case (reg_idx)
            qmsm_pkg::REG_COEF_SQUARE:   prdata = {16'b0, square_reg};
            qmsm_pkg::REG_COEF_LINEAR:   prdata = {16'b0, linear_reg};
            qmsm_pkg::REG_COEF_CONSTANT: prdata = {16'b0, constant_reg};
            default:                     prdata = '0;
        endcase
    end

    assign coef.square   = square_reg;
    assign coef.linear   = linear_reg;
    assign coef.constant = constant_reg;

endmodule

// ===== design/qmsm_front.sv =====
// Front end: accepts samples and marks the one that closes a set.
// Depends on qmsm_pkg and qmsm_in_if; feeds qmsm_queue.
module qmsm_front #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    qmsm_in_if.sink             sample_in,
    output logic                push_valid,
    input  logic                push_ready,
    output qmsm_pkg::q_entry_t  push_data
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [IW-1:0] count_reg;
    logic [IW-1:0] count_next;
    logic          is_last;
    logic          accept;

    // A set closes on its marker or when the store is full.
    assign is_last = sample_in.end_of_set || (count_reg == IW'(MAX_ITEMS - 1));
    assign accept  = sample_in.valid && push_ready;

    assign sample_in.ready  = push_ready;
    assign push_valid       = sample_in.valid;
    assign push_data.sample = sample_in.sample;
    assign push_data.last   = is_last;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = is_last ? '0 : count_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/qmsm_queue.sv =====
// Short queue between the front and back ends.
// Depends on qmsm_pkg for the entry type and depth.
module qmsm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  qmsm_pkg::q_entry_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output qmsm_pkg::q_entry_t  pop_data
);

    localparam int DEPTH = qmsm_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    qmsm_pkg::q_entry_t entry_reg [DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [CNTW-1:0]    count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNTW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNTW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNTW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/qmsm_back.sv =====
// Back end: stores a set, maps it through the quadratic and merges it from both ends.
// Depends on qmsm_pkg and qmsm_out_if; fed by qmsm_queue.
module qmsm_back #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  qmsm_pkg::coef_t     coef,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  qmsm_pkg::q_entry_t  pop_data,
    qmsm_out_if.source          result_out,
    output qmsm_pkg::back_stat_t stat
);

    localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int PLW = (CW > qmsm_pkg::POS_W) ? CW : qmsm_pkg::POS_W;
    localparam int VW  = qmsm_pkg::VALUE_W;

    // Sample and mapped-value memories.
    logic signed [qmsm_pkg::SAMPLE_W-1:0] sample_mem [MAX_ITEMS];
    logic signed [VW-1:0]                 mapped_mem [MAX_ITEMS];

    qmsm_pkg::back_state_t state_reg, state_next;
    logic [IW-1:0]  wr_idx_reg, wr_idx_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  n_m1;
    logic [CW-1:0]  map_issue_reg, map_issue_next;
    logic           issue_en;

    // Mapping pipeline.
    logic                                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [IW-1:0]                        s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [qmsm_pkg::SAMPLE_W-1:0] x_reg;
    logic signed [31:0]                   sq_reg;
    logic signed [31:0]                   bx2_reg;
    logic signed [31:0]                   bx3_reg;
    logic signed [47:0]                   axx_reg;
    logic signed [47:0]                   map_sum;
    logic signed [qmsm_pkg::COEF_W-1:0]   coef_a;
    logic signed [qmsm_pkg::COEF_W-1:0]   coef_b;
    logic signed [qmsm_pkg::COEF_W-1:0]   coef_c;

    // Merge.
    logic [IW-1:0]        front_reg, front_next;
    logic [IW-1:0]        back_reg, back_next;
    logic [PLW-1:0]       place_reg, place_next;
    logic [CW-1:0]        remain_reg, remain_next;
    logic                 fill_down_reg, fill_down_next;
    logic signed [VW-1:0] rdf_reg, rdb_reg;
    logic                 take_front;
    logic                 step;

    // Output register.
    logic                        out_valid_reg, out_valid_next;
    logic signed [VW-1:0]        out_value_reg, out_value_next;
    logic [qmsm_pkg::POS_W-1:0]  out_pos_reg, out_pos_next;
    logic                        out_end_reg, out_end_next;

    assign coef_a = coef.square;
    assign coef_b = coef.linear;
    assign coef_c = coef.constant;
    assign n_m1   = n_reg - CW'(1);

    assign map_sum = axx_reg + {{16{bx3_reg[31]}}, bx3_reg} + {{32{coef_c[15]}}, coef_c};

    // Fill down keeps the larger end value, front on ties; fill up keeps the smaller, back on ties.
    assign take_front = fill_down_reg ? (rdf_reg >= rdb_reg) : (rdf_reg < rdb_reg);

    assign pop_ready    = (state_reg == qmsm_pkg::BK_LOAD);
    assign stat.loading = (state_reg == qmsm_pkg::BK_LOAD);
    assign stat.merging = (state_reg == qmsm_pkg::BK_MERGE);

    assign result_out.valid        = out_valid_reg;
    assign result_out.mapped_value = out_value_reg;
    assign result_out.position     = out_pos_reg;
    assign result_out.end_of_run   = out_end_reg;

    // Next state and control.
    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        n_next         = n_reg;
        map_issue_next = map_issue_reg;
        issue_en       = 1'b0;
        front_next     = front_reg;
        back_next      = back_reg;
        place_next     = place_reg;
        remain_next    = remain_reg;
        fill_down_next = fill_down_reg;
        step           = 1'b0;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        out_end_next   = out_end_reg;

        unique case (state_reg)
            qmsm_pkg::BK_LOAD:
            begin
                if (pop_valid)
                begin
                    if (pop_data.last)
                    begin
                        wr_idx_next    = '0;
                        n_next         = CW'(wr_idx_reg) + CW'(1);
                        map_issue_next = '0;
                        state_next     = qmsm_pkg::BK_MAP;
                    end
                    else
                    begin
                        wr_idx_next = wr_idx_reg + IW'(1);
                    end
                end
            end
            qmsm_pkg::BK_MAP:
            begin
                if (map_issue_reg < n_reg)
                begin
                    issue_en       = 1'b1;
                    map_issue_next = map_issue_reg + CW'(1);
                end
                if (s3_valid_reg && (s3_idx_reg == n_m1[IW-1:0]))
                begin
                    fill_down_next = !coef_a[qmsm_pkg::COEF_W-1];
                    state_next     = qmsm_pkg::BK_PRIME;
                end
            end
            qmsm_pkg::BK_PRIME:
            begin
                front_next  = '0;
                back_next   = n_m1[IW-1:0];
                place_next  = fill_down_reg ? (PLW'(n_reg) - PLW'(1)) : '0;
                remain_next = n_reg;
                state_next  = qmsm_pkg::BK_MERGE;
            end
            qmsm_pkg::BK_MERGE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    step = 1'b1;
                    if (take_front)
                    begin
                        front_next = front_reg + IW'(1);
                    end
                    else
                    begin
                        back_next = back_reg - IW'(1);
                    end
                    place_next  = fill_down_reg ? place_reg - PLW'(1) : place_reg + PLW'(1);
                    remain_next = remain_reg - CW'(1);
                    if (remain_reg == CW'(1))
                    begin
                        state_next = qmsm_pkg::BK_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = qmsm_pkg::BK_LOAD;
            end
        endcase

        // Output slot: load on a merge step, empty when taken.
        if (step)
        begin
            out_valid_next = 1'b1;
            out_value_next = take_front ? rdf_reg : rdb_reg;
            out_pos_next   = place_reg[qmsm_pkg::POS_W-1:0];
            out_end_next   = (remain_reg == CW'(1));
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qmsm_pkg::BK_LOAD;
            wr_idx_reg    <= '0;
            n_reg         <= '0;
            map_issue_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            front_reg     <= '0;
            back_reg      <= '0;
            place_reg     <= '0;
            remain_reg    <= '0;
            fill_down_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            n_reg         <= n_next;
            map_issue_reg <= map_issue_next;
            s1_valid_reg  <= issue_en;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            front_reg     <= front_next;
            back_reg      <= back_next;
            place_reg     <= place_next;
            remain_reg    <= remain_next;
            fill_down_reg <= fill_down_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Mapping pipeline data: square and linear term, then the quadratic term.
    always_ff @(posedge clk)
    begin
        s1_idx_reg <= map_issue_reg[IW-1:0];
        sq_reg     <= x_reg * x_reg;
        bx2_reg    <= coef_b * x_reg;
        s2_idx_reg <= s1_idx_reg;
        axx_reg    <= sq_reg * coef_a;
        bx3_reg    <= bx2_reg;
        s3_idx_reg <= s2_idx_reg;
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_end_reg   <= out_end_next;
    end

    // Sample memory: written while loading, read once per entry while mapping.
    always_ff @(posedge clk)
    begin
        if (pop_valid && pop_ready)
        begin
            sample_mem[wr_idx_reg] <= pop_data.sample;
        end
        if (issue_en)
        begin
            x_reg <= sample_mem[map_issue_reg[IW-1:0]];
        end
    end

    // Mapped memory: written by the pipeline, read at both merge ends.
    always_ff @(posedge clk)
    begin
        if (s3_valid_reg)
        begin
            mapped_mem[s3_idx_reg] <= map_sum[VW-1:0];
        end
        rdf_reg <= mapped_mem[front_next];
        rdb_reg <= mapped_mem[back_next];
    end

endmodule

// ===== design/quadratic_map_sorted_merge_top.sv =====
// Top level of the quadratic map sorted merge block.
// Depends on qmsm_pkg, qmsm_in_if, qmsm_out_if, qmsm_cfg, qmsm_front, qmsm_queue, qmsm_back.
//
// Samples of an ascending set arrive one per transaction and are stored at one per
// cycle while the back end is loading; a set ends on end_of_set or on its MAX_ITEMS-th
// sample. After the last sample of a set of n, a mapping sweep computes a*x*x + b*x + c
// exactly for every stored sample through a three-stage multiply pipeline, a priming
// state reads both ends, and the merge then emits one result per cycle while the
// output is taken. The dual-read mapped-value memory sets the merge rate; the mapping
// pipeline sets the sweep. While a set is mapped and merged the two-entry queue takes
// up to two samples of the next set, then holds ready low. Results come in merge order,
// each with its place in the ascending result: with a >= 0 places count down from n - 1,
// with a < 0 they count up from 0. Coefficients must be written through the APB port
// only while the block is idle; the block itself does not enforce this.
module quadratic_map_sorted_merge_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qmsm_pkg::APB_AW-1:0] paddr,
    input  logic [qmsm_pkg::APB_DW-1:0] pwdata,
    output logic [qmsm_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    qmsm_in_if.sink                     sample_in,
    qmsm_out_if.source                  result_out
);

    qmsm_pkg::coef_t      coef;
    qmsm_pkg::q_entry_t   q_push_data;
    qmsm_pkg::q_entry_t   q_pop_data;
    qmsm_pkg::back_stat_t stat;
    logic                 q_push_valid;
    logic                 q_push_ready;
    logic                 q_pop_valid;
    logic                 q_pop_ready;

    qmsm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    qmsm_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    qmsm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    qmsm_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .result_out (result_out),
        .stat       (stat)
    );

    // A full queue never lets a sample in.
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !q_push_ready |-> !(sample_in.valid && sample_in.ready))
        else $error("sample accepted while the queue was full");

    // A new result only appears after a merge cycle.
    a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> $past(stat.merging))
        else $error("result appeared outside the merge");

    // While merging with an empty output slot, the slot fills on the next cycle.
    a_merge_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.merging && !result_out.valid) |=> result_out.valid)
        else $error("merge stalled with a free output slot");

    // Loading ends only when the last sample of a set leaves the queue.
    a_load_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(stat.loading) |-> $past(q_pop_valid && q_pop_ready && q_pop_data.last))
        else $error("loading ended without the last sample");

endmodule

// ===== verif/tb_quadratic_map_sorted_merge_top.sv =====
// Self-checking testbench for quadratic_map_sorted_merge_top.
// Depends on qmsm_pkg, qmsm_in_if, qmsm_out_if and the block's RTL; drives sets of samples,
// predicts every mapped value and its sorted place, and compares each result transaction.
`timescale 1ns / 1ps

module tb_quadratic_map_sorted_merge_top;

    localparam int MAX_ITEMS      = 64;
    localparam int PHASE_COUNT    = 10;
    localparam int ITEMS_PER_SET  = 6;
    localparam int SETTLE_CYCLES  = 2 * MAX_ITEMS + 40;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int REPORT_LIMIT   = 10;

    // Register index with no register behind it; writes there must be ignored.
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic signed [qmsm_pkg::SAMPLE_W-1:0] sample;
        logic                                 end_of_set;
    } sample_item_t;

    typedef struct {
        logic signed [qmsm_pkg::VALUE_W-1:0] value;
        logic [qmsm_pkg::POS_W-1:0]          position;
        logic                                end_of_run;
    } mapped_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [qmsm_pkg::APB_AW-1:0] paddr;
    logic [qmsm_pkg::APB_DW-1:0] pwdata;
    logic [qmsm_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    qmsm_in_if  sample_if ();
    qmsm_out_if result_if ();

    quadratic_map_sorted_merge_top #(
        .MAX_ITEMS (MAX_ITEMS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample_in  (sample_if),
        .result_out (result_if)
    );

    always #5 clk = ~clk;

    // Predictor state: coefficient copies and the samples of the set being loaded.
    logic signed [qmsm_pkg::COEF_W-1:0]   sq_coef    = qmsm_pkg::COEF_SQUARE_RST;
    logic signed [qmsm_pkg::COEF_W-1:0]   lin_coef   = qmsm_pkg::COEF_LINEAR_RST;
    logic signed [qmsm_pkg::COEF_W-1:0]   const_coef = qmsm_pkg::COEF_CONSTANT_RST;
    logic signed [qmsm_pkg::SAMPLE_W-1:0] loaded_samples [MAX_ITEMS];
    int                                   loaded_count = 0;

    sample_item_t   pending_items [$];
    mapped_result_t expected_results [$];
    sample_item_t   next_item;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int ready_mode     = 0;
    int mode_left      = 0;
    bit ready_toggle   = 1'b0;

    // Exact quadratic image of one sample under the current coefficients.
    function automatic longint quad_image(logic signed [qmsm_pkg::SAMPLE_W-1:0] x);
        longint xv;
        xv = longint'(x);
        return longint'(sq_coef) * xv * xv + longint'(lin_coef) * xv + longint'(const_coef);
    endfunction

    // Stores one accepted sample; on the last one of a set, runs the two-ended merge and
    // queues every result it yields.
    function automatic void merge_mapped_set(logic signed [qmsm_pkg::SAMPLE_W-1:0] s,
                                             logic eos);
        int             n;
        int             lo;
        int             hi;
        int             place;
        bit             fill_down;
        longint         f_lo;
        longint         f_hi;
        longint         pick;
        mapped_result_t r;
        loaded_samples[loaded_count] = s;
        loaded_count++;
        if (!eos && loaded_count < MAX_ITEMS)
            return;
        n = loaded_count;
        fill_down = (sq_coef >= 0);
        lo = 0;
        hi = n - 1;
        place = fill_down ? n - 1 : 0;
        for (int k = 0; k < n; k++)
        begin
            f_lo = quad_image(loaded_samples[lo]);
            f_hi = quad_image(loaded_samples[hi]);
            // Larger end first when filling down (front wins ties), smaller end first
            // when filling up (back wins ties).
            if (fill_down)
            begin
                if (f_lo >= f_hi)
                begin
                    pick = f_lo;
                    lo++;
                end
                else
                begin
                    pick = f_hi;
                    hi--;
                end
            end
            else
            begin
                if (f_lo >= f_hi)
                begin
                    pick = f_hi;
                    hi--;
                end
                else
                begin
                    pick = f_lo;
                    lo++;
                end
            end
            r.value      = pick[qmsm_pkg::VALUE_W-1:0];
            r.position   = place[qmsm_pkg::POS_W-1:0];
            r.end_of_run = (k == n - 1);
            expected_results.push_back(r);
            place = fill_down ? place - 1 : place + 1;
        end
        loaded_count = 0;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Sample driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_if.valid      <= 1'b0;
            sample_if.sample     <= '0;
            sample_if.end_of_set <= 1'b0;
        end
        else
        begin
            if (sample_if.valid && sample_if.ready)
                merge_mapped_set(sample_if.sample, sample_if.end_of_set);
            if (!sample_if.valid || sample_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_if.valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    next_item = pending_items.pop_front();
                    sample_if.sample     <= next_item.sample;
                    sample_if.end_of_set <= next_item.end_of_set;
                    sample_if.valid      <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    sample_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: ready follows stretches of always-ready, alternating and random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch($sformatf("unexpected result value=%0d position=%0d",
                                            result_if.mapped_value, result_if.position));
                else
                begin
                    mapped_result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (result_if.mapped_value !== exp_r.value
                        || result_if.position !== exp_r.position
                        || result_if.end_of_run !== exp_r.end_of_run)
                        note_mismatch($sformatf(
                            "expected value=%0d position=%0d end=%0b, got %0d %0d %0b",
                            exp_r.value, exp_r.position, exp_r.end_of_run,
                            result_if.mapped_value, result_if.position,
                            result_if.end_of_run));
                end
            end
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(5, 40);
            end
            mode_left--;
            ready_toggle = ~ready_toggle;
            case (ready_mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= ready_toggle;
                default: result_if.ready <= ($urandom_range(0, 9) < 6);
            endcase
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_item(int s, bit eos);
        sample_item_t it;
        it.sample     = s[qmsm_pkg::SAMPLE_W-1:0];
        it.end_of_set = eos;
        pending_items.push_back(it);
    endtask

    // One set of random content: ascending unless broken, full range or a narrow range
    // that produces ties. Only a full-size set may end without the marker.
    task automatic push_random_set(int len, bit mark_last);
        int vals [$];
        bit narrow;
        narrow = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
        begin
            if (narrow)
                vals.push_back(int'($urandom_range(0, 16)) - 8);
            else
                vals.push_back(int'($urandom_range(0, 65535)) - 32768);
        end
        vals.sort();
        if ($urandom_range(0, 9) == 0)
            vals.shuffle();
        for (int k = 0; k < len; k++)
            push_item(vals[k], (k == len - 1) ? mark_last : 1'b0);
    endtask

    task automatic apb_write(logic [1:0] idx, logic signed [qmsm_pkg::COEF_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(qmsm_pkg::APB_DW - qmsm_pkg::COEF_W){value[qmsm_pkg::COEF_W-1]}},
                    value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            qmsm_pkg::REG_COEF_SQUARE:   sq_coef    = value;
            qmsm_pkg::REG_COEF_LINEAR:   lin_coef   = value;
            qmsm_pkg::REG_COEF_CONSTANT: const_coef = value;
            default: ;
        endcase
    endtask

    // Waits until the sample side is drained and every expected result has come.
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_items.size() != 0 || sample_if.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sq_tab [PHASE_COUNT]    = '{1, -1, 32767, -32768, 0, 0, 0, 0, 0, 0};
        int lin_tab [PHASE_COUNT]   = '{0, 3, -32768, 32767, 5, -1, 0, 0, 0, 0};
        int const_tab [PHASE_COUNT] = '{0, -7, 32767, -32768, 100, 0, 0, 0, 0, 0};
        int added;
        int len;

        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Later phases use random coefficients, sometimes tiny ones.
        for (int p = 6; p < PHASE_COUNT; p++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                sq_tab[p]    = int'($urandom_range(0, 8)) - 4;
                lin_tab[p]   = int'($urandom_range(0, 8)) - 4;
                const_tab[p] = int'($urandom_range(0, 8)) - 4;
            end
            else
            begin
                sq_tab[p]    = int'($urandom_range(0, 65535)) - 32768;
                lin_tab[p]   = int'($urandom_range(0, 65535)) - 32768;
                const_tab[p] = int'($urandom_range(0, 65535)) - 32768;
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            // The first phase runs on the reset coefficients.
            if (p > 0)
            begin
                wait_idle();
                apb_write(qmsm_pkg::REG_COEF_SQUARE, sq_tab[p][qmsm_pkg::COEF_W-1:0]);
                apb_write(qmsm_pkg::REG_COEF_LINEAR, lin_tab[p][qmsm_pkg::COEF_W-1:0]);
                apb_write(qmsm_pkg::REG_COEF_CONSTANT, const_tab[p][qmsm_pkg::COEF_W-1:0]);
                if (p == 3)
                    apb_write(REG_UNMAPPED, 16'h5A5A);
            end
            @(negedge clk);

            if (p == 0)
            begin
                // Sample extremes, a single-sample set, a pair with equal images, an unsorted set and
                // a set of identical samples, all on the reset mapping x*x.
                push_item(-32768, 0); push_item(-5, 0); push_item(0, 0);
                push_item(7, 0); push_item(32767, 1);
                push_item(12345, 1);
                push_item(-3, 0); push_item(3, 1);
                push_item(5, 0); push_item(-10, 0); push_item(2, 1);
                push_item(-1, 0); push_item(-1, 0); push_item(-1, 1);
            end
            else if (p == 1)
            begin
                // Negative a: extremes, and pairs whose images tie so the back end wins.
                push_item(-32768, 0); push_item(32767, 1);
                push_item(-2, 0); push_item(5, 1);
                push_item(1, 0); push_item(2, 1);
                push_item(0, 1);
            end
            else if (p == 2)
                push_random_set(MAX_ITEMS, 1'b0);
            else if (p == 3)
                push_random_set(MAX_ITEMS, 1'b1);

            added = 0;
            while (added < ITEMS_PER_SET)
            begin
                if ($urandom_range(0, 29) == 0)
                    len = MAX_ITEMS;
                else
                    len = $urandom_range(1, 10);
                push_random_set(len, (len == MAX_ITEMS) ? 1'($urandom_range(0, 1)) : 1'b1);
                added += len;
            end
        end

        wait_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
